>>> hw/rtl/i2crs_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Shared codes, state encodings and the queued job record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crs_pkg;

    // Request modes
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    // Commands to the byte-level controller
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_SEND     = 3'd2;
    localparam logic [2:0] CMD_READ_NAK = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;
    localparam logic [2:0] CMD_BACKOFF  = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_CTRL_WRITE = 3'd1;
    localparam logic [2:0] ERR_REG_ADDR   = 3'd2;
    localparam logic [2:0] ERR_RESTART    = 3'd3;
    localparam logic [2:0] ERR_CTRL_READ  = 3'd4;
    localparam logic [2:0] ERR_READ_DATA  = 3'd5;
    localparam logic [2:0] ERR_WRITE_DATA = 3'd6;

    // Controller status codes
    localparam logic [7:0] ST_CTRL_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_CTRL_R_ACK = 8'h40;
    localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

    localparam logic [7:0] RD_FAIL = 8'hFF;

    // Configuration register indexes and reset values
    localparam logic       CFG_SLAVE_ADDR = 1'b0;
    localparam logic       CFG_MAX_ATT    = 1'b1;
    localparam int         CFG_DW         = 7;
    localparam logic [6:0] SLAVE_ADDR_RST = 7'd29;
    localparam logic [2:0] MAX_ATT_RST    = 3'd2;

    // Job queue between front and back
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START      = 3'd1,
        PH_CTRL_WRITE = 3'd2,
        PH_REG        = 3'd3,
        PH_RESTART    = 3'd4,
        PH_CTRL_READ  = 3'd5,
        PH_READ_DATA  = 3'd6,
        PH_WRITE_DATA = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        JOB_ONE   = 2'd0,
        JOB_RETRY = 2'd1,
        JOB_FAIL  = 2'd2
    } t_job_kind;

    // One queued job expands to one, two or three results.
    typedef struct packed {
        t_job_kind  kind;
        logic [2:0] cmd;
        logic [7:0] tx;
        logic       done;
        logic [2:0] err;
        logic [7:0] rd;
    } t_job;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       last;
        logic       done_res;
        logic [2:0] error_code;
        logic [7:0] read_data;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/i2crs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying start requests and controller status reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2crs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [7:0] status_code;
    logic [7:0] rx_byte;

    modport source (
        output valid, mode, reg_addr, write_value, status_code, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, reg_addr, write_value, status_code, rx_byte,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/i2crs_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying controller commands and completion status.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2crs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       last;
    logic       done_res;
    logic [2:0] error_code;
    logic [7:0] read_data;

    modport source (
        output valid, command, tx_byte, last, done_res, error_code, read_data,
        input  ready
    );
    modport sink (
        input  valid, command, tx_byte, last, done_res, error_code, read_data,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/i2crs_front.sv
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts requests, tracks the transaction phase and queues result jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crs_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    i2crs_req_if.sink                  i_req,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [i2crs_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire                        i_q_full,
    output logic                       o_push,
    output i2crs_pkg::t_job            o_job
);
    import i2crs_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_is_read, n_is_read;
    logic [7:0] r_reg_addr, n_reg_addr;
    logic [7:0] r_wr_value, n_wr_value;
    logic [2:0] r_attempts, n_attempts;
    logic [6:0] r_slave_addr;
    logic [2:0] r_max_att;

    logic       accept, is_start, is_stat;
    logic       st_ok, retry;
    logic [2:0] err, limit;
    logic [3:0] tries;
    logic [7:0] wctl;

    assign i_req.ready = !i_q_full;
    assign accept   = i_req.valid && !i_q_full;
    assign is_start = (i_req.mode == MODE_READ) || (i_req.mode == MODE_WRITE);
    assign is_stat  = (i_req.mode == MODE_STATUS);
    assign wctl     = {r_slave_addr, 1'b0};
    assign limit    = (r_max_att == 3'd0) ? 3'd1 : r_max_att;
    assign tries    = {1'b0, r_attempts} + 4'd1;
    assign retry    = tries < {1'b0, limit};

    // Expected status and error number for each phase
    always_comb begin
        st_ok = 1'b0;
        err   = ERR_OK;
        unique case (r_phase)
            PH_IDLE:       begin st_ok = 1'b0; err = ERR_OK; end
            PH_START:      begin st_ok = 1'b1; err = ERR_OK; end
            PH_CTRL_WRITE: begin
                st_ok = (i_req.status_code == ST_CTRL_W_ACK);
                err   = ERR_CTRL_WRITE;
            end
            PH_REG: begin
                st_ok = (i_req.status_code == ST_DATA_W_ACK);
                err   = ERR_REG_ADDR;
            end
            PH_RESTART: begin
                st_ok = (i_req.status_code == ST_RESTART) ||
                        (i_req.status_code == ST_START);
                err   = ERR_RESTART;
            end
            PH_CTRL_READ: begin
                st_ok = (i_req.status_code == ST_CTRL_R_ACK);
                err   = ERR_CTRL_READ;
            end
            PH_READ_DATA: begin
                st_ok = (i_req.status_code == ST_DATA_R_NAK);
                err   = ERR_READ_DATA;
            end
            PH_WRITE_DATA: begin
                st_ok = (i_req.status_code == ST_DATA_W_ACK);
                err   = ERR_WRITE_DATA;
            end
            default:       begin st_ok = 1'b0; err = ERR_OK; end
        endcase
    end

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_is_read  = r_is_read;
        n_reg_addr = r_reg_addr;
        n_wr_value = r_wr_value;
        n_attempts = r_attempts;
        if (accept && is_start && r_phase == PH_IDLE) begin
            n_is_read  = (i_req.mode == MODE_READ);
            n_reg_addr = i_req.reg_addr;
            n_wr_value = i_req.write_value;
            n_attempts = 3'd0;
            n_phase    = PH_START;
        end else if (accept && is_stat && r_phase != PH_IDLE) begin
            if (!st_ok) begin
                n_attempts = tries[2:0];
                n_phase    = retry ? PH_START : PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_IDLE:       n_phase = PH_IDLE;
                    PH_START:      n_phase = PH_CTRL_WRITE;
                    PH_CTRL_WRITE: n_phase = PH_REG;
                    PH_REG:        n_phase = r_is_read ? PH_RESTART : PH_WRITE_DATA;
                    PH_RESTART:    n_phase = PH_CTRL_READ;
                    PH_CTRL_READ:  n_phase = PH_READ_DATA;
                    PH_READ_DATA:  n_phase = PH_IDLE;
                    PH_WRITE_DATA: n_phase = PH_IDLE;
                    default:       n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Job to queue
    always_comb begin
        o_push     = 1'b0;
        o_job.kind = JOB_ONE;
        o_job.cmd  = CMD_NONE;
        o_job.tx   = 8'd0;
        o_job.done = 1'b0;
        o_job.err  = ERR_OK;
        o_job.rd   = 8'd0;
        if (accept && is_start && r_phase == PH_IDLE) begin
            o_push    = 1'b1;
            o_job.cmd = CMD_START;
        end else if (accept && is_stat && r_phase != PH_IDLE) begin
            o_push = 1'b1;
            if (!st_ok) begin
                o_job.kind = retry ? JOB_RETRY : JOB_FAIL;
                o_job.err  = err;
                o_job.rd   = (r_is_read && !retry) ? RD_FAIL : 8'd0;
            end else begin
                unique case (r_phase)
                    PH_IDLE:       o_job.cmd = CMD_NONE;
                    PH_START: begin
                        o_job.cmd = CMD_SEND;
                        o_job.tx  = wctl;
                    end
                    PH_CTRL_WRITE: begin
                        o_job.cmd = CMD_SEND;
                        o_job.tx  = r_reg_addr;
                    end
                    PH_REG: begin
                        o_job.cmd = r_is_read ? CMD_START : CMD_SEND;
                        o_job.tx  = r_is_read ? 8'd0 : r_wr_value;
                    end
                    PH_RESTART: begin
                        o_job.cmd = CMD_SEND;
                        o_job.tx  = wctl | 8'd1;
                    end
                    PH_CTRL_READ:  o_job.cmd = CMD_READ_NAK;
                    PH_READ_DATA: begin
                        o_job.cmd  = CMD_STOP;
                        o_job.done = 1'b1;
                        o_job.rd   = i_req.rx_byte;
                    end
                    PH_WRITE_DATA: begin
                        o_job.cmd  = CMD_STOP;
                        o_job.done = 1'b1;
                    end
                    default:       o_job.cmd = CMD_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_read    <= 1'b0;
            r_reg_addr   <= 8'd0;
            r_wr_value   <= 8'd0;
            r_attempts   <= 3'd0;
            r_slave_addr <= SLAVE_ADDR_RST;
            r_max_att    <= MAX_ATT_RST;
        end else begin
            r_phase    <= n_phase;
            r_is_read  <= n_is_read;
            r_reg_addr <= n_reg_addr;
            r_wr_value <= n_wr_value;
            r_attempts <= n_attempts;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLAVE_ADDR) begin
                    r_slave_addr <= i_cfg_data[6:0];
                end else begin
                    r_max_att <= i_cfg_data[2:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2crs_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO decoupling the front end from the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crs_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  i2crs_pkg::t_job i_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output i2crs_pkg::t_job o_head
);
    import i2crs_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2crs_back.sv
// ----------------------------------------------------------------------------
// Sequencer back end
// Expands queued jobs into results, one per unstalled cycle, via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crs_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  i2crs_pkg::t_job i_head,
    output logic            o_pop,
    i2crs_res_if.source     o_res
);
    import i2crs_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_res       r_res;
    t_res       res;
    logic       is_last, load;

    assign load  = !r_valid || o_res.ready;
    assign o_pop = load && !i_empty && is_last;

    // Result number r_idx of the job at the head of the queue
    always_comb begin
        res.command    = i_head.cmd;
        res.tx_byte    = i_head.tx;
        res.done_res   = i_head.done;
        res.error_code = ERR_OK;
        res.read_data  = i_head.rd;
        is_last        = 1'b1;
        unique case (i_head.kind)
            JOB_ONE: is_last = 1'b1;
            JOB_RETRY: begin
                res.tx_byte   = 8'd0;
                res.done_res  = 1'b0;
                res.read_data = 8'd0;
                if (r_idx == 2'd0) begin
                    res.command    = CMD_STOP;
                    res.error_code = i_head.err;
                    is_last        = 1'b0;
                end else if (r_idx == 2'd1) begin
                    res.command    = CMD_BACKOFF;
                    res.error_code = i_head.err;
                    is_last        = 1'b0;
                end else begin
                    res.command = CMD_START;
                end
            end
            JOB_FAIL: begin
                res.tx_byte    = 8'd0;
                res.error_code = i_head.err;
                if (r_idx == 2'd0) begin
                    res.command   = CMD_STOP;
                    res.done_res  = 1'b0;
                    res.read_data = 8'd0;
                    is_last       = 1'b0;
                end else begin
                    res.command  = CMD_BACKOFF;
                    res.done_res = 1'b1;
                end
            end
            default: is_last = 1'b1;
        endcase
        res.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.command    = r_res.command;
    assign o_res.tx_byte    = r_res.tx_byte;
    assign o_res.last       = r_res.last;
    assign o_res.done_res   = r_res.done_res;
    assign o_res.error_code = r_res.error_code;
    assign o_res.read_data  = r_res.read_data;

endmodule

`default_nettype wire

>>> hw/rtl/i2c_register_access_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C register access sequencer core
// Steps a byte-level I2C controller through a register read or write.
// ----------------------------------------------------------------------------
// The first result of an accepted transaction passes through the job queue and
// the output register. Results leave one per cycle while the sink is ready;
// an item yields one to three results.
// A request may be accepted every cycle while the four-entry job queue has room.
// Reset (synchronous, active low) returns the phase to idle, empties the queue and
// output register, and sets the address to 29 and the attempt limit to 2.
`default_nettype none

module i2c_register_access_sequencer_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    i2crs_req_if.sink                   i_req,
    i2crs_res_if.source                 o_res,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire [i2crs_pkg::CFG_DW-1:0] i_cfg_data
);
    import i2crs_pkg::*;

    // The front end classifies each transaction on acceptance: it advances
    // the phase, decides success, retry or failure, and records the resulting
    // commands as one compact job.
    logic q_push, q_pop, q_full, q_empty;
    t_job push_job, head_job;

    i2crs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    // The queue lets new status reports be taken while the back end is still
    // emitting the stop, backoff and restart commands of a failed try.
    i2crs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // The back end expands each job into its results, one per cycle, and
    // holds them in an output register until the sink takes them.
    i2crs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_job),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/i2crs_checker.sv
// ----------------------------------------------------------------------------
// Sequencer port checker
// Checks result channel properties visible at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crs_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       i_ready,
    input wire [2:0] i_command,
    input wire       i_last,
    input wire       i_done_res,
    input wire [2:0] i_error_code,
    input wire [7:0] i_read_data
);
    import i2crs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done_res |-> i_last)
        else $error("transaction finished on a non-final result");

    a_err_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != ERR_OK |->
            (i_command == CMD_STOP || i_command == CMD_BACKOFF))
        else $error("error code on a command other than stop or backoff");

    a_backoff_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_command == CMD_BACKOFF |-> i_error_code != ERR_OK)
        else $error("backoff without an error code");

    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_read_data != 8'd0 |-> i_done_res)
        else $error("read data on an unfinished transaction");

endmodule

bind i2c_register_access_sequencer_core i2crs_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_command    (o_res.command),
    .i_last       (o_res.last),
    .i_done_res   (o_res.done_res),
    .i_error_code (o_res.error_code),
    .i_read_data  (o_res.read_data)
);

`default_nettype wire
